>>> design/patch_pair_filter_defines.svh
// Assertion macros used by the patch pair filter
`ifndef PATCH_PAIR_FILTER_DEFINES_SVH
`define PATCH_PAIR_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled in reset
`define PPF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled in reset
`define PPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ppf_pkg.sv
// Types and constants of the patch pair filter
`timescale 1ns / 1ps

package ppf_pkg;

  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DIST_W     = 42;
  localparam int unsigned DOT_W      = 30;
  localparam int unsigned MAXDOT_W   = 29;
  localparam int unsigned COORD_IN_W = 20;
  localparam int unsigned NRM_IN_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 42;

  localparam logic [MAXDOT_W-1:0] MAX_DOT_RESET = 29'h1000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST_SQ = 2'd0,
    CFG_MAX_ABS_DOT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]  first_index;
    logic [DIST_W-1:0] distance_sq;
    logic [DOT_W-1:0]  abs_dot;
  } pair_t;

  typedef struct packed {
    logic valid;
    logic fin;
  } ctl_t;

endpackage

>>> design/ppf_if.sv
// Request channel interfaces of the patch pair filter
`timescale 1ns / 1ps

interface ppf_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      start_req;
  logic signed [ppf_pkg::COORD_IN_W-1:0]     center_x;
  logic signed [ppf_pkg::COORD_IN_W-1:0]     center_y;
  logic signed [ppf_pkg::COORD_IN_W-1:0]     center_z;
  logic signed [ppf_pkg::NRM_IN_W-1:0]       normal_x;
  logic signed [ppf_pkg::NRM_IN_W-1:0]       normal_y;
  logic signed [ppf_pkg::NRM_IN_W-1:0]       normal_z;

  modport source (output valid, start_req, center_x, center_y, center_z,
                  normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, start_req, center_x, center_y, center_z,
                normal_x, normal_y, normal_z, output ready);
endinterface

interface ppf_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppf_pkg::IDX_W-1:0]    first_index;
  logic [ppf_pkg::IDX_W-1:0]    second_index;
  logic [ppf_pkg::DIST_W-1:0]   distance_sq;
  logic [ppf_pkg::DOT_W-1:0]    abs_dot;
  logic                         last;

  modport source (output valid, first_index, second_index, distance_sq, abs_dot, last,
                  input ready);
  modport sink (input valid, first_index, second_index, distance_sq, abs_dot, last,
                output ready);
endinterface

interface ppf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ppf_pkg::CFG_IDX_W-1:0]    index;
  logic [ppf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/ppf_cell.sv
// One storage cell of the rotating patch ring
`timescale 1ns / 1ps

module ppf_cell #(
  parameter int unsigned CW = 20,
  parameter int unsigned NW = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2:0][CW-1:0]  center_i,
  input  logic [2:0][NW-1:0]  normal_i,
  output logic [2:0][CW-1:0]  center_o,
  output logic [2:0][NW-1:0]  normal_o
);

  logic [2:0][CW-1:0] center_q;
  logic [2:0][NW-1:0] normal_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      center_q <= center_i;
      normal_q <= normal_i;
    end
  end

  assign center_o = center_q;
  assign normal_o = normal_q;

endmodule

>>> design/ppf_pair_unit.sv
// Two-stage distance and normal test of the new patch against one stored patch
`timescale 1ns / 1ps

module ppf_pair_unit #(
  parameter int unsigned CW = 20,
  parameter int unsigned NW = 16,
  parameter int unsigned DOT_SHIFT = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ppf_pkg::ctl_t                   ctl_i,
  input  logic [ppf_pkg::IDX_W-1:0]       idx_i,
  input  logic [2:0][CW-1:0]              new_center_i,
  input  logic [2:0][NW-1:0]              new_normal_i,
  input  logic [2:0][CW-1:0]              old_center_i,
  input  logic [2:0][NW-1:0]              old_normal_i,
  input  logic [ppf_pkg::DIST_W-1:0]      min_dist_sq_i,
  input  logic [ppf_pkg::MAXDOT_W-1:0]    max_abs_dot_i,
  output ppf_pkg::ctl_t                   ctl_o,
  output ppf_pkg::pair_t                  pair_o
);

  localparam int unsigned SQ_W  = 2 * CW;
  localparam int unsigned DSQ_W = 2 * CW + 2;
  localparam int unsigned PR_W  = 2 * NW;

  logic signed [CW:0]       diff [3];
  logic signed [2*CW+1:0]   sq_full [3];
  logic signed [PR_W-1:0]   prod_d [3];

  logic [SQ_W-1:0]          sq_q [3];
  logic signed [PR_W-1:0]   prod_q [3];
  logic [ppf_pkg::IDX_W-1:0] idx_q;
  ppf_pkg::ctl_t            ctl_q;

  logic [DSQ_W-1:0]         dsq;
  logic signed [PR_W-1:0]   dot;
  logic [PR_W-1:0]          dot_mag;
  logic [ppf_pkg::DIST_W-1:0] dsq_ext;
  logic [ppf_pkg::DOT_W-1:0]  adot;
  logic                     pass;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]    = $signed({new_center_i[k][CW-1], new_center_i[k]})
                 - $signed({old_center_i[k][CW-1], old_center_i[k]});
      sq_full[k] = diff[k] * diff[k];
      prod_d[k]  = $signed(new_normal_i[k]) * $signed(old_normal_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k]   <= sq_full[k][SQ_W-1:0];
        prod_q[k] <= prod_d[k];
      end
      idx_q <= idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_comb begin
    dsq     = DSQ_W'(sq_q[0]) + DSQ_W'(sq_q[1]) + DSQ_W'(sq_q[2]);
    dot     = prod_q[0] + prod_q[1] + prod_q[2];
    dot_mag = dot[PR_W-1] ? PR_W'(-dot) : PR_W'(dot);
    dsq_ext = ppf_pkg::DIST_W'(dsq);
    adot    = ppf_pkg::DOT_W'(dot_mag) << DOT_SHIFT;
    pass    = (dsq_ext >= min_dist_sq_i) && (adot <= {1'b0, max_abs_dot_i});
  end

  assign ctl_o.valid        = ctl_q.valid && pass;
  assign ctl_o.fin          = ctl_q.fin;
  assign pair_o.first_index = idx_q;
  assign pair_o.distance_sq = dsq_ext;
  assign pair_o.abs_dot     = adot;

endmodule

>>> design/patch_pair_filter.sv
// Top level of the patch pair filter
//
// Channels: patch_i takes one patch per request (center, unit normal, start mark);
// pair_o gives one request per kept pair, last marking the final pair of a patch;
// cfg_i writes min_distance_sq (index 0) and max_abs_dot (index 1).
// Stored patches sit in a ring of MAX_PATCHES cells that rotates once per patch;
// the cell at the head feeds a two-stage test unit, one stored patch per cycle,
// and the new patch drops into the ring at its own slot as the ring goes by.
// A new patch is taken only in idle, after the full turn of the ring and the drain
// state of the patch before it.
// Each kept pair passes the test unit register, the held pair and the output
// register; each pair is held back one kept pair so that last is known.
// A patch with no start mark that meets a full ring is dropped in the accept cycle.
// Reset empties the patch set and loads the register defaults; the ring needs
// no clearing since only written slots are tested.
// When pair_o stalls, the ring, the test unit and the held pair all freeze.
// Configuration is taken any cycle; write it only while the block is idle.
`timescale 1ns / 1ps
`include "patch_pair_filter_defines.svh"

module patch_pair_filter #(
  parameter int unsigned MAX_PATCHES      = 64,
  parameter int unsigned COORD_BITS       = 20,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ppf_cfg_if.sink        cfg_i,
  ppf_in_if.sink         patch_i,
  ppf_out_if.source      pair_o
);

  localparam int unsigned PW        = $clog2(MAX_PATCHES);
  localparam int unsigned CNT_W     = $clog2(MAX_PATCHES + 1);
  localparam int unsigned NRM_W     = NORMAL_FRAC_BITS + 2;
  localparam int unsigned DOT_SHIFT = 2 * (14 - NORMAL_FRAC_BITS);
  localparam logic signed [ppf_pkg::NRM_IN_W-1:0] NLIM =
    ppf_pkg::NRM_IN_W'(1 << NORMAL_FRAC_BITS);
  localparam logic [PW-1:0] P_LAST = PW'(MAX_PATCHES - 1);

  function automatic logic [NRM_W-1:0] clamp_nrm(input logic signed [ppf_pkg::NRM_IN_W-1:0] v);
    logic signed [ppf_pkg::NRM_IN_W-1:0] r;
    if (v > NLIM) begin
      r = NLIM;
    end else if (v < -NLIM) begin
      r = -NLIM;
    end else begin
      r = v;
    end
    return r[NRM_W-1:0];
  endfunction

  // Configuration registers
  logic [ppf_pkg::DIST_W-1:0]   min_dist_sq_q;
  logic [ppf_pkg::MAXDOT_W-1:0] max_abs_dot_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_sq_q <= '0;
      max_abs_dot_q <= ppf_pkg::MAX_DOT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ppf_pkg::CFG_MIN_DIST_SQ: min_dist_sq_q <= cfg_i.data;
        ppf_pkg::CFG_MAX_ABS_DOT: max_abs_dot_q <= cfg_i.data[ppf_pkg::MAXDOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  ppf_pkg::state_e state_q, state_d;
  logic [PW-1:0]    p_q, p_d;
  logic [CNT_W-1:0] count_q, j_q, count_eff;
  logic             accept, take, adv, unit_en, ring_en;

  assign adv       = !pair_o.valid || pair_o.ready;
  assign unit_en   = adv && (state_q != ppf_pkg::ST_IDLE);
  assign ring_en   = adv && (state_q == ppf_pkg::ST_RUN);
  assign accept    = patch_i.valid && patch_i.ready;
  assign count_eff = patch_i.start_req ? '0 : count_q;
  assign take      = accept && (count_eff < CNT_W'(MAX_PATCHES));
  assign patch_i.ready = (state_q == ppf_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    unique case (state_q)
      ppf_pkg::ST_IDLE: begin
        if (take) begin
          state_d = ppf_pkg::ST_RUN;
          p_d     = '0;
        end
      end
      ppf_pkg::ST_RUN: begin
        if (adv) begin
          if (p_q == P_LAST) begin
            state_d = ppf_pkg::ST_DRAIN;
            p_d     = '0;
          end else begin
            p_d = p_q + 1'b1;
          end
        end
      end
      ppf_pkg::ST_DRAIN: begin
        if (adv) begin
          state_d = ppf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppf_pkg::ST_IDLE;
        p_d     = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppf_pkg::ST_IDLE;
      p_q     <= '0;
      count_q <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      if (accept) begin
        count_q <= take ? CNT_W'(count_eff + 1'b1) : count_eff;
      end
      if (take) begin
        j_q <= count_eff;
      end
    end
  end

  // New patch, held for the whole turn of the ring
  logic [2:0][COORD_BITS-1:0] new_c_q;
  logic [2:0][NRM_W-1:0]      new_n_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      new_c_q[0] <= patch_i.center_x[COORD_BITS-1:0];
      new_c_q[1] <= patch_i.center_y[COORD_BITS-1:0];
      new_c_q[2] <= patch_i.center_z[COORD_BITS-1:0];
      new_n_q[0] <= clamp_nrm(patch_i.normal_x);
      new_n_q[1] <= clamp_nrm(patch_i.normal_y);
      new_n_q[2] <= clamp_nrm(patch_i.normal_z);
    end
  end

  // Ring of cells: head holds slot p_q, the tail takes the head back or the new patch
  logic [2:0][COORD_BITS-1:0] ring_c [MAX_PATCHES];
  logic [2:0][NRM_W-1:0]      ring_n [MAX_PATCHES];
  logic [2:0][COORD_BITS-1:0] tail_c;
  logic [2:0][NRM_W-1:0]      tail_n;
  logic                       slot_new;

  assign slot_new = (CNT_W'(p_q) == j_q);
  assign tail_c   = slot_new ? new_c_q : ring_c[0];
  assign tail_n   = slot_new ? new_n_q : ring_n[0];

  for (genvar g = 0; g < MAX_PATCHES; g++) begin : g_ring
    if (g == MAX_PATCHES - 1) begin : g_tail
      ppf_cell #(.CW(COORD_BITS), .NW(NRM_W)) u_cell (
        .clk_i    (clk_i),
        .en_i     (ring_en),
        .center_i (tail_c),
        .normal_i (tail_n),
        .center_o (ring_c[g]),
        .normal_o (ring_n[g])
      );
    end else begin : g_body
      ppf_cell #(.CW(COORD_BITS), .NW(NRM_W)) u_cell (
        .clk_i    (clk_i),
        .en_i     (ring_en),
        .center_i (ring_c[g+1]),
        .normal_i (ring_n[g+1]),
        .center_o (ring_c[g]),
        .normal_o (ring_n[g])
      );
    end
  end

  // Test unit
  ppf_pkg::ctl_t  unit_ctl_in, unit_ctl_out;
  ppf_pkg::pair_t unit_pair;

  always_comb begin
    unit_ctl_in = '0;
    if (state_q == ppf_pkg::ST_RUN) begin
      unit_ctl_in.valid = (CNT_W'(p_q) < j_q);
      unit_ctl_in.fin   = (p_q == P_LAST);
    end
  end

  ppf_pair_unit #(
    .CW        (COORD_BITS),
    .NW        (NRM_W),
    .DOT_SHIFT (DOT_SHIFT)
  ) u_unit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (unit_en),
    .ctl_i         (unit_ctl_in),
    .idx_i         (ppf_pkg::IDX_W'(p_q)),
    .new_center_i  (new_c_q),
    .new_normal_i  (new_n_q),
    .old_center_i  (ring_c[0]),
    .old_normal_i  (ring_n[0]),
    .min_dist_sq_i (min_dist_sq_q),
    .max_abs_dot_i (max_abs_dot_q),
    .ctl_o         (unit_ctl_out),
    .pair_o        (unit_pair)
  );

  // Hold one kept pair back so the final one can carry last
  logic                      pend_v_q;
  ppf_pkg::pair_t            pend_q;
  logic                      out_v_q, out_last_q;
  ppf_pkg::pair_t            out_q;
  logic [ppf_pkg::IDX_W-1:0] out_sec_q;
  logic                      push_mid, push_last;

  assign push_mid  = unit_en && unit_ctl_out.valid && pend_v_q;
  assign push_last = unit_en && unit_ctl_out.fin && pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (unit_en && unit_ctl_out.valid) begin
        pend_v_q <= 1'b1;
      end else if (push_last) begin
        pend_v_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_v_q <= 1'b1;
      end else if (pair_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (unit_en && unit_ctl_out.valid) begin
      pend_q <= unit_pair;
    end
    if (push_mid || push_last) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
      out_sec_q  <= ppf_pkg::IDX_W'(j_q);
    end
  end

  assign pair_o.valid        = out_v_q;
  assign pair_o.first_index  = out_q.first_index;
  assign pair_o.second_index = out_sec_q;
  assign pair_o.distance_sq  = out_q.distance_sq;
  assign pair_o.abs_dot      = out_q.abs_dot;
  assign pair_o.last         = out_last_q;

  `PPF_ASSERT(a_pend_empty_idle, state_q == ppf_pkg::ST_IDLE, !pend_v_q, "held pair left over at idle")
  `PPF_ASSERT(a_ring_aligned_idle, state_q == ppf_pkg::ST_IDLE, p_q == '0, "ring not aligned at idle")
  `PPF_ASSERT(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_PATCHES), "patch count beyond capacity")
  `PPF_ASSERT_NEXT(a_drain_done, state_q == ppf_pkg::ST_DRAIN && adv, state_q == ppf_pkg::ST_IDLE && !pend_v_q, "drain did not release the held pair")

endmodule

>>> verif/tb_patch_pair_filter.sv
// Self-checking testbench of the patch pair filter: directed and random patches, scored pairs
`timescale 1ns / 1ps

module tb_patch_pair_filter;

  localparam int MAX_PATCHES      = 64;
  localparam int COORD_BITS       = 20;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int DOT_SHIFT        = 2 * (14 - NORMAL_FRAC_BITS);
  localparam int SETTLE_CYCLES    = MAX_PATCHES + 8;
  localparam int TIMEOUT_NS       = 20_000_000;

  typedef struct packed {
    logic                           start_req;
    logic [ppf_pkg::COORD_IN_W-1:0] center_x;
    logic [ppf_pkg::COORD_IN_W-1:0] center_y;
    logic [ppf_pkg::COORD_IN_W-1:0] center_z;
    logic [ppf_pkg::NRM_IN_W-1:0]   normal_x;
    logic [ppf_pkg::NRM_IN_W-1:0]   normal_y;
    logic [ppf_pkg::NRM_IN_W-1:0]   normal_z;
  } patch_t;

  typedef struct {
    logic [ppf_pkg::IDX_W-1:0]  first_index;
    logic [ppf_pkg::IDX_W-1:0]  second_index;
    logic [ppf_pkg::DIST_W-1:0] distance_sq;
    logic [ppf_pkg::DOT_W-1:0]  abs_dot;
    logic                       last;
  } pair_exp_t;

  logic clk_i;
  logic rst_ni;

  ppf_cfg_if cfg_if ();
  ppf_in_if  patch_if ();
  ppf_out_if pair_if ();

  patch_pair_filter #(
    .MAX_PATCHES     (MAX_PATCHES),
    .COORD_BITS      (COORD_BITS),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .patch_i(patch_if),
    .pair_o (pair_if)
  );

  // Mirror of the block: stored patches and registers
  longint                       center_mem [MAX_PATCHES][3];
  longint                       normal_mem [MAX_PATCHES][3];
  int                           stored_cnt;
  logic [ppf_pkg::DIST_W-1:0]   min_dist_sq_reg;
  logic [ppf_pkg::MAXDOT_W-1:0] max_dot_reg;

  pair_exp_t pair_expect_q[$];

  int  fail_cnt;
  int  patches_sent;
  int  patches_dropped;
  int  pairs_checked;
  int  cfg_writes;
  int  widest_batch;
  bit  calm;
  int  hold_left;
  int  stall_left;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic longint coord_value(input logic [ppf_pkg::COORD_IN_W-1:0] raw);
    longint v;
    v = longint'(raw);
    v = (v <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
    return v;
  endfunction

  function automatic longint clamped_normal(input logic [ppf_pkg::NRM_IN_W-1:0] raw);
    longint v;
    longint lim;
    v   = longint'(signed'(raw));
    lim = longint'(1) << NORMAL_FRAC_BITS;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Compare the new patch with every stored one and queue the kept pairs
  task automatic predict_pairs(input patch_t p);
    longint    c[3];
    longint    n[3];
    longint    d;
    longint    dsq;
    longint    dot;
    longint    adot;
    pair_exp_t e;
    int        kept;
    if (p.start_req) stored_cnt = 0;
    if (stored_cnt >= MAX_PATCHES) begin
      patches_dropped++;
      return;
    end
    c[0] = coord_value(p.center_x);
    c[1] = coord_value(p.center_y);
    c[2] = coord_value(p.center_z);
    n[0] = clamped_normal(p.normal_x);
    n[1] = clamped_normal(p.normal_y);
    n[2] = clamped_normal(p.normal_z);
    kept = 0;
    for (int i = 0; i < stored_cnt; i++) begin
      dsq = 0;
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        d   = c[k] - center_mem[i][k];
        dsq += d * d;
        dot += n[k] * normal_mem[i][k];
      end
      adot = ((dot < 0) ? -dot : dot) <<< DOT_SHIFT;
      if (dsq >= longint'(min_dist_sq_reg) && adot <= longint'(max_dot_reg)) begin
        e.first_index  = ppf_pkg::IDX_W'(i);
        e.second_index = ppf_pkg::IDX_W'(stored_cnt);
        e.distance_sq  = ppf_pkg::DIST_W'(dsq);
        e.abs_dot      = ppf_pkg::DOT_W'(adot);
        e.last         = 1'b0;
        pair_expect_q.insert(pair_expect_q.size(), e);
        kept++;
      end
    end
    if (kept > 0) begin
      pair_expect_q[pair_expect_q.size() - 1].last = 1'b1;
    end
    if (kept > widest_batch) widest_batch = kept;
    for (int k = 0; k < 3; k++) begin
      center_mem[stored_cnt][k] = c[k];
      normal_mem[stored_cnt][k] = n[k];
    end
    stored_cnt++;
  endtask

  always @(posedge clk_i) begin : cfg_monitor
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      cfg_writes++;
      case (ppf_pkg::cfg_reg_e'(cfg_if.index))
        ppf_pkg::CFG_MIN_DIST_SQ: min_dist_sq_reg = cfg_if.data[ppf_pkg::DIST_W-1:0];
        ppf_pkg::CFG_MAX_ABS_DOT: max_dot_reg = cfg_if.data[ppf_pkg::MAXDOT_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : patch_monitor
    patch_t p;
    if (rst_ni && patch_if.valid && patch_if.ready) begin
      p.start_req = patch_if.start_req;
      p.center_x  = patch_if.center_x;
      p.center_y  = patch_if.center_y;
      p.center_z  = patch_if.center_z;
      p.normal_x  = patch_if.normal_x;
      p.normal_y  = patch_if.normal_y;
      p.normal_z  = patch_if.normal_z;
      predict_pairs(p);
    end
  end

  always @(posedge clk_i) begin : pair_check
    pair_exp_t e;
    if (rst_ni && pair_if.valid && pair_if.ready) begin
      if (pair_expect_q.size() == 0) begin
        $error("unexpected pair %0d-%0d", pair_if.first_index, pair_if.second_index);
        fail_cnt++;
      end else begin
        e = pair_expect_q.pop_front();
        pairs_checked++;
        if (pair_if.first_index !== e.first_index) begin
          $error("first_index mismatch: expected %0d, got %0d",
                 e.first_index, pair_if.first_index);
          fail_cnt++;
        end
        if (pair_if.second_index !== e.second_index) begin
          $error("second_index mismatch: expected %0d, got %0d",
                 e.second_index, pair_if.second_index);
          fail_cnt++;
        end
        if (pair_if.distance_sq !== e.distance_sq) begin
          $error("distance_sq mismatch: expected %0d, got %0d",
                 e.distance_sq, pair_if.distance_sq);
          fail_cnt++;
        end
        if (pair_if.abs_dot !== e.abs_dot) begin
          $error("abs_dot mismatch: expected %0d, got %0d", e.abs_dot, pair_if.abs_dot);
          fail_cnt++;
        end
        if (pair_if.last !== e.last) begin
          $error("last mismatch: expected %0d, got %0d", e.last, pair_if.last);
          fail_cnt++;
        end
      end
    end
  end

  // Pair receiver: long hold-off first, then random stalls
  always @(posedge clk_i) begin : pair_ready_drive
    if (hold_left > 0) begin
      pair_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      pair_if.ready <= 1'b0;
      stall_left--;
    end else begin
      pair_if.ready <= 1'b1;
      if (!calm) stall_left = idle_len();
    end
  end

  function automatic patch_t make_patch(input logic st, input int cx, input int cy,
                                        input int cz, input int nx, input int ny,
                                        input int nz);
    patch_t p;
    p.start_req = st;
    p.center_x  = ppf_pkg::COORD_IN_W'(cx);
    p.center_y  = ppf_pkg::COORD_IN_W'(cy);
    p.center_z  = ppf_pkg::COORD_IN_W'(cz);
    p.normal_x  = ppf_pkg::NRM_IN_W'(nx);
    p.normal_y  = ppf_pkg::NRM_IN_W'(ny);
    p.normal_z  = ppf_pkg::NRM_IN_W'(nz);
    return p;
  endfunction

  function automatic int rand_coord();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return int'($urandom());
    if (m < 8) return int'($urandom_range(0, 2000)) - 1000;
    if (m == 8) return -524288;
    return 524287;
  endfunction

  function automatic int rand_normal();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return int'($urandom_range(0, 32768)) - 16384;
    if (m < 8) begin
      case ($urandom_range(0, 2))
        0: return 16384;
        1: return -16384;
        default: return 0;
      endcase
    end
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic patch_t rand_patch(input logic st);
    return make_patch(st, rand_coord(), rand_coord(), rand_coord(),
                      rand_normal(), rand_normal(), rand_normal());
  endfunction

  task automatic send_patch(input patch_t p);
    int gap;
    patch_if.valid     <= 1'b1;
    patch_if.start_req <= p.start_req;
    patch_if.center_x  <= p.center_x;
    patch_if.center_y  <= p.center_y;
    patch_if.center_z  <= p.center_z;
    patch_if.normal_x  <= p.normal_x;
    patch_if.normal_y  <= p.normal_y;
    patch_if.normal_z  <= p.normal_z;
    do @(posedge clk_i); while (!patch_if.ready);
    patches_sent++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      patch_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every pair, then let a patch with no pairs finish
  task automatic wait_idle();
    patch_if.valid <= 1'b0;
    while (pair_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input ppf_pkg::cfg_reg_e idx,
                           input logic [ppf_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ppf_pkg::CFG_DATA_W-1:0] rand_min_dist();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ppf_pkg::CFG_DATA_W'(r[35:0]);
      2: return ppf_pkg::CFG_DATA_W'(r[39:0]);
      default: return r[ppf_pkg::CFG_DATA_W-1:0];
    endcase
  endfunction

  function automatic logic [ppf_pkg::CFG_DATA_W-1:0] rand_max_dot();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 2))
      0: return ppf_pkg::CFG_DATA_W'(ppf_pkg::MAX_DOT_RESET);
      1: return ppf_pkg::CFG_DATA_W'($urandom_range(0, 32'h1000_0000));
      default: return r[ppf_pkg::CFG_DATA_W-1:0];
    endcase
  endfunction

  task automatic write_random_config();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(ppf_pkg::CFG_MIN_DIST_SQ, rand_min_dist());
      write_reg(ppf_pkg::CFG_MAX_ABS_DOT, rand_max_dot());
    end else begin
      write_reg(ppf_pkg::CFG_MAX_ABS_DOT, rand_max_dot());
      write_reg(ppf_pkg::CFG_MIN_DIST_SQ, rand_min_dist());
    end
  endtask

  // A run opens with a start mark, except now and then a broken one that keeps the set
  task automatic send_run(input int len);
    logic st;
    for (int k = 0; k < len; k++) begin
      if (k == 0) st = ($urandom_range(0, 9) != 0);
      else st = ($urandom_range(0, 29) == 0);
      send_patch(rand_patch(st));
    end
  endtask

  task automatic test_defaults_and_extremes();
    send_patch(make_patch(1'b1, 524287, 524287, 524287, 16384, 0, 0));
    send_patch(make_patch(1'b0, -524288, -524288, -524288, -16384, 0, 0));
    send_patch(make_patch(1'b0, 0, 0, 0, 0, 16384, 0));
    send_patch(make_patch(1'b0, 0, 0, 0, 0, 16384, 0));
    // out-of-range normals clamp to unit magnitude
    send_patch(make_patch(1'b0, 1, -1, 7, 32767, -32768, 16385));
    send_patch(make_patch(1'b0, -1, -1, -1, -1, -16385, 0));
    wait_idle();
  endtask

  task automatic test_thresholds();
    // minimum distance above any reachable one with zero dot limit: nothing passes
    write_reg(ppf_pkg::CFG_MIN_DIST_SQ, 42'h300_0000_0000);
    write_reg(ppf_pkg::CFG_MAX_ABS_DOT, '0);
    send_patch(make_patch(1'b1, -524288, -524288, -524288, 16384, 0, 0));
    send_patch(make_patch(1'b0, 524287, 524287, 524287, 0, 16384, 0));
    send_patch(make_patch(1'b0, 524287, -524288, 524287, 0, 0, 16384));
    wait_idle();
    // zero dot limit keeps only perpendicular normals
    write_reg(ppf_pkg::CFG_MIN_DIST_SQ, '0);
    send_patch(make_patch(1'b1, 10, 0, 0, 16384, 0, 0));
    send_patch(make_patch(1'b0, 0, 10, 0, 0, -16384, 0));
    send_patch(make_patch(1'b0, 0, 0, 10, 0, 0, 16384));
    send_patch(make_patch(1'b0, 5, 5, 5, -16384, 0, 0));
    wait_idle();
    // both limits met with equality are kept
    write_reg(ppf_pkg::CFG_MIN_DIST_SQ, 42'd25);
    write_reg(ppf_pkg::CFG_MAX_ABS_DOT, 42'h800_0000);
    send_patch(make_patch(1'b1, 0, 0, 0, 16384, 0, 0));
    send_patch(make_patch(1'b0, 3, 4, 0, 0, 16384, 0));
    send_patch(make_patch(1'b0, 5, 0, 1, 0, 0, 16384));
    send_patch(make_patch(1'b0, 100, 0, 0, 8192, 0, 0));
    send_patch(make_patch(1'b0, 0, 0, -200, 8193, 0, 0));
    wait_idle();
    write_reg(ppf_pkg::CFG_MAX_ABS_DOT, ppf_pkg::CFG_DATA_W'(ppf_pkg::MAX_DOT_RESET));
    write_reg(ppf_pkg::CFG_MIN_DIST_SQ, '0);
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    calm      = 1'b1;
    send_patch(rand_patch(1'b1));
    for (int k = 0; k < 9; k++) send_patch(rand_patch(1'b0));
    calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_capacity();
    write_reg(ppf_pkg::CFG_MIN_DIST_SQ,
              ppf_pkg::CFG_DATA_W'({$urandom_range(0, 255), 32'h0}));
    write_reg(ppf_pkg::CFG_MAX_ABS_DOT, ppf_pkg::CFG_DATA_W'(32'h800_0000));
    send_patch(rand_patch(1'b1));
    for (int k = 1; k < MAX_PATCHES + 4; k++) send_patch(rand_patch(1'b0));
    // a start mark on a full set clears it again
    send_patch(rand_patch(1'b1));
    send_patch(rand_patch(1'b0));
    wait_idle();
  endtask

  task automatic test_random_phase(input int items, input bit quiet);
    int sent;
    int len;
    write_random_config();
    calm = quiet;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(2, 12);
      send_run(len);
      sent += len;
    end
    calm = 1'b0;
    wait_idle();
  endtask

  initial begin : main
    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = ppf_pkg::CFG_MIN_DIST_SQ;
    cfg_if.data        = '0;
    patch_if.valid     = 1'b0;
    patch_if.start_req = 1'b0;
    patch_if.center_x  = '0;
    patch_if.center_y  = '0;
    patch_if.center_z  = '0;
    patch_if.normal_x  = '0;
    patch_if.normal_y  = '0;
    patch_if.normal_z  = '0;
    pair_if.ready      = 1'b0;
    stored_cnt         = 0;
    min_dist_sq_reg    = '0;
    max_dot_reg        = ppf_pkg::MAX_DOT_RESET;
    fail_cnt           = 0;
    patches_sent       = 0;
    patches_dropped    = 0;
    pairs_checked      = 0;
    cfg_writes         = 0;
    widest_batch       = 0;
    calm               = 1'b0;
    hold_left          = 0;
    stall_left         = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_extremes();
    test_thresholds();
    test_backpressure();
    test_capacity();
    test_random_phase(70, 1'b0);
    test_random_phase(70, 1'b1);
    test_random_phase(70, 1'b0);
    test_random_phase(70, 1'b0);
    test_random_phase(70, 1'b0);

    if (pair_expect_q.size() != 0) begin
      $error("%0d expected pairs never arrived", pair_expect_q.size());
      fail_cnt++;
    end
    $display("run covered %0d patches (%0d dropped at capacity), %0d register writes",
             patches_sent, patches_dropped, cfg_writes);
    $display("%0d pairs checked, up to %0d pairs from one patch", pairs_checked,
             widest_batch);
    if (fail_cnt == 0) begin
      $display("patch_pair_filter regression: pass");
    end else begin
      $display("patch_pair_filter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("patch_pair_filter regression: fail");
    $finish;
  end

endmodule
